[design/c32dfr_pkg.sv]
// ----------------------------------------------------------------------------
// c32dfr_pkg
// Shared types, constants and the CRC-32C byte update for the frame deframer.
// ----------------------------------------------------------------------------
package c32dfr_pkg;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

  // frame layout, in 17-bit position units
  localparam logic [16:0] MAGIC_BYTES   = 17'd4;
  localparam logic [16:0] HEADER_BYTES  = 17'd14;
  localparam logic [16:0] TRAILER_BYTES = 17'd4;

  // status codes
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_ACCEPT  = 2'd1;
  localparam logic [1:0] ST_HDR_REJ = 2'd2;
  localparam logic [1:0] ST_CRC_BAD = 2'd3;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MAGIC       = 2'd0;
  localparam logic [1:0] REG_VERSION     = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

  typedef struct packed {
    logic [31:0] magic;
    logic [7:0]  version;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  msg_type;
    logic [15:0] msg_flags;
    logic [31:0] msg_sequence;
    logic [15:0] msg_payload_length;
    logic [31:0] bad_frames;
  } res_t;

  // reflected CRC-32C, one byte
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

[design/c32dfr_regs.sv]
// ----------------------------------------------------------------------------
// c32dfr_regs
// APB-style configuration registers: magic, version, max_payload.
// ----------------------------------------------------------------------------
module c32dfr_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output c32dfr_pkg::cfg_t   cfg
);

  c32dfr_pkg::cfg_t cfg_r;
  c32dfr_pkg::cfg_t cfg_nxt;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        c32dfr_pkg::REG_MAGIC:       cfg_nxt.magic       = pwdata;
        c32dfr_pkg::REG_VERSION:     cfg_nxt.version     = pwdata[7:0];
        c32dfr_pkg::REG_MAX_PAYLOAD: cfg_nxt.max_payload = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      c32dfr_pkg::REG_MAGIC:       prdata = cfg_r.magic;
      c32dfr_pkg::REG_VERSION:     prdata = {24'd0, cfg_r.version};
      c32dfr_pkg::REG_MAX_PAYLOAD: prdata = {16'd0, cfg_r.max_payload};
      default:                     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic       <= 32'd0;
      cfg_r.version     <= 8'd1;
      cfg_r.max_payload <= 16'd256;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[design/c32dfr_parser.sv]
// ----------------------------------------------------------------------------
// c32dfr_parser
// Frame state, header capture, CRC-32C accumulation and the per-byte result.
// ----------------------------------------------------------------------------
module c32dfr_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [7:0]         rx_byte,
  input  c32dfr_pkg::cfg_t   cfg,
  output c32dfr_pkg::res_t   res
);

  // header byte positions
  localparam logic [3:0] HB_VERSION = 4'd4;
  localparam logic [3:0] HB_TYPE    = 4'd5;
  localparam logic [3:0] HB_FLAGS0  = 4'd6;
  localparam logic [3:0] HB_FLAGS1  = 4'd7;
  localparam logic [3:0] HB_SEQ0    = 4'd8;
  localparam logic [3:0] HB_SEQ1    = 4'd9;
  localparam logic [3:0] HB_SEQ2    = 4'd10;
  localparam logic [3:0] HB_SEQ3    = 4'd11;
  localparam logic [3:0] HB_LEN0    = 4'd12;

  logic [16:0] pos_r,      pos_nxt;
  logic [16:0] total_r,    total_nxt;
  logic [31:0] crc_r,      crc_nxt;
  logic [31:0] crc_rx_r,   crc_rx_nxt;
  logic [7:0]  hdr_ver_r,  hdr_ver_nxt;
  logic [7:0]  hdr_type_r, hdr_type_nxt;
  logic [15:0] hdr_flg_r,  hdr_flg_nxt;
  logic [31:0] hdr_seq_r,  hdr_seq_nxt;
  logic [15:0] hdr_len_r,  hdr_len_nxt;
  logic [31:0] rej_r,      rej_nxt;

  logic [31:0] crc_b;
  logic        rs_hit;
  logic [16:0] rs_pos;
  logic [31:0] rs_crc;
  logic [15:0] len_full;
  logic [16:0] pay_end;
  logic [16:0] trl_off;
  logic [31:0] crc_rx_upd;
  logic [16:0] pos_inc;
  logic [16:0] pay_off;
  logic [7:0]  magic_exp;

  always_comb begin
    case (pos_r[1:0])
      2'd0:    magic_exp = cfg.magic[7:0];
      2'd1:    magic_exp = cfg.magic[15:8];
      2'd2:    magic_exp = cfg.magic[23:16];
      default: magic_exp = cfg.magic[31:24];
    endcase
  end

  assign crc_b      = c32dfr_pkg::crc32c_byte(crc_r, rx_byte);
  assign rs_hit     = (rx_byte == cfg.magic[7:0]);
  assign rs_pos     = rs_hit ? 17'd1 : 17'd0;
  assign rs_crc     = rs_hit ? c32dfr_pkg::crc32c_byte(c32dfr_pkg::CRC_INIT, rx_byte)
                             : c32dfr_pkg::CRC_INIT;
  assign len_full   = {rx_byte, hdr_len_r[7:0]};
  assign pay_end    = c32dfr_pkg::HEADER_BYTES + {1'b0, hdr_len_r};
  assign trl_off    = pos_r - pay_end;
  assign crc_rx_upd = crc_rx_r | ({24'd0, rx_byte} << {trl_off[1:0], 3'b000});
  assign pos_inc    = pos_r + 17'd1;
  assign pay_off    = pos_r - c32dfr_pkg::HEADER_BYTES;

  always_comb begin
    pos_nxt      = pos_r;
    total_nxt    = total_r;
    crc_nxt      = crc_r;
    crc_rx_nxt   = crc_rx_r;
    hdr_ver_nxt  = hdr_ver_r;
    hdr_type_nxt = hdr_type_r;
    hdr_flg_nxt  = hdr_flg_r;
    hdr_seq_nxt  = hdr_seq_r;
    hdr_len_nxt  = hdr_len_r;
    rej_nxt      = rej_r;
    res          = '0;

    if (pos_r < c32dfr_pkg::MAGIC_BYTES) begin
      if (rx_byte == magic_exp) begin
        crc_nxt = crc_b;
        pos_nxt = pos_inc;
      end else begin
        pos_nxt    = rs_pos;
        total_nxt  = 17'd0;
        crc_nxt    = rs_crc;
        crc_rx_nxt = 32'd0;
      end
    end else begin
      pos_nxt = pos_inc;
      if (pos_r < c32dfr_pkg::HEADER_BYTES) begin
        crc_nxt = crc_b;
        case (pos_r[3:0])
          HB_VERSION: hdr_ver_nxt  = rx_byte;
          HB_TYPE:    hdr_type_nxt = rx_byte;
          HB_FLAGS0:  hdr_flg_nxt  = {8'd0, rx_byte};
          HB_FLAGS1:  hdr_flg_nxt  = {rx_byte, hdr_flg_r[7:0]};
          HB_SEQ0:    hdr_seq_nxt  = {24'd0, rx_byte};
          HB_SEQ1:    hdr_seq_nxt  = {16'd0, rx_byte, hdr_seq_r[7:0]};
          HB_SEQ2:    hdr_seq_nxt  = {8'd0, rx_byte, hdr_seq_r[15:0]};
          HB_SEQ3:    hdr_seq_nxt  = {rx_byte, hdr_seq_r[23:0]};
          HB_LEN0:    hdr_len_nxt  = {8'd0, rx_byte};
          default: begin
            // last header byte: length high byte, then the header check
            hdr_len_nxt = len_full;
            if ((len_full > cfg.max_payload) || (hdr_ver_r != cfg.version)) begin
              rej_nxt    = rej_r + 32'd1;
              res.status = c32dfr_pkg::ST_HDR_REJ;
              pos_nxt    = rs_pos;
              total_nxt  = 17'd0;
              crc_nxt    = rs_crc;
              crc_rx_nxt = 32'd0;
            end else begin
              total_nxt  = c32dfr_pkg::HEADER_BYTES + c32dfr_pkg::TRAILER_BYTES
                           + {1'b0, len_full};
              crc_rx_nxt = 32'd0;
            end
          end
        endcase
      end else if (pos_r < pay_end) begin
        crc_nxt           = crc_b;
        res.payload_valid = 1'b1;
        res.payload_byte  = rx_byte;
        res.payload_index = pay_off[15:0];
      end else begin
        crc_rx_nxt = crc_rx_upd;
        if (pos_inc >= total_r) begin
          if (~crc_r != crc_rx_upd) begin
            rej_nxt    = rej_r + 32'd1;
            res.status = c32dfr_pkg::ST_CRC_BAD;
            pos_nxt    = rs_pos;
            total_nxt  = 17'd0;
            crc_nxt    = rs_crc;
            crc_rx_nxt = 32'd0;
          end else begin
            // good frame: back to hunting, current byte not reused
            res.status             = c32dfr_pkg::ST_ACCEPT;
            res.msg_type           = hdr_type_r;
            res.msg_flags          = hdr_flg_r;
            res.msg_sequence       = hdr_seq_r;
            res.msg_payload_length = hdr_len_r;
            pos_nxt    = 17'd0;
            total_nxt  = 17'd0;
            crc_nxt    = c32dfr_pkg::CRC_INIT;
            crc_rx_nxt = 32'd0;
          end
        end
      end
    end
    res.bad_frames = rej_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 17'd0;
      total_r    <= 17'd0;
      crc_r      <= c32dfr_pkg::CRC_INIT;
      crc_rx_r   <= 32'd0;
      hdr_ver_r  <= 8'd0;
      hdr_type_r <= 8'd0;
      hdr_flg_r  <= 16'd0;
      hdr_seq_r  <= 32'd0;
      hdr_len_r  <= 16'd0;
      rej_r      <= 32'd0;
    end else if (in_fire) begin
      pos_r      <= pos_nxt;
      total_r    <= total_nxt;
      crc_r      <= crc_nxt;
      crc_rx_r   <= crc_rx_nxt;
      hdr_ver_r  <= hdr_ver_nxt;
      hdr_type_r <= hdr_type_nxt;
      hdr_flg_r  <= hdr_flg_nxt;
      hdr_seq_r  <= hdr_seq_nxt;
      hdr_len_r  <= hdr_len_nxt;
      rej_r      <= rej_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_total_unknown_in_header: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r < c32dfr_pkg::HEADER_BYTES) |-> (total_r == 17'd0))
    else $error("frame length set before header complete");

  a_total_matches_len: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r >= c32dfr_pkg::HEADER_BYTES) |->
      (total_r == c32dfr_pkg::HEADER_BYTES + c32dfr_pkg::TRAILER_BYTES + {1'b0, hdr_len_r}))
    else $error("frame length disagrees with header length");

  a_pos_below_total: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r >= c32dfr_pkg::HEADER_BYTES) |-> (pos_r < total_r))
    else $error("position ran past frame end");

  a_reject_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && ((res.status == c32dfr_pkg::ST_HDR_REJ) ||
                 (res.status == c32dfr_pkg::ST_CRC_BAD)))
      |=> (rej_r == $past(rej_r) + 32'd1))
    else $error("reject not counted");

  a_payload_undecided: assert property (@(posedge clk) disable iff (!rst_n)
    res.payload_valid |-> (res.status == c32dfr_pkg::ST_NONE))
    else $error("payload byte carries a status");
`endif

endmodule

[design/crc32c_frame_deframer_unit.sv]
// Output: the result of each accepted byte is registered in the output register.
// Throughput: one byte per cycle unless out_ready stalls a waiting result; set by
// the byte-wide CRC-32C update and position counter in the parser. A byte is taken
// while a result waits if the consumer takes that result in the same cycle.
// Reset: sync, active low; registers but res_r to defaults, parser hunting magic.
// ----------------------------------------------------------------------------
// crc32c_frame_deframer_unit
// Byte-serial deframer for magic-synced, length-prefixed CRC-32C frames.
// ----------------------------------------------------------------------------
module crc32c_frame_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_payload_index,
  output logic [7:0]  out_msg_type,
  output logic [15:0] out_msg_flags,
  output logic [31:0] out_msg_sequence,
  output logic [15:0] out_msg_payload_length,
  output logic [31:0] out_bad_frames
);

  c32dfr_pkg::cfg_t cfg;
  c32dfr_pkg::res_t res_nxt;
  c32dfr_pkg::res_t res_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             in_fire;

  assign in_ready      = ~out_valid_r | out_ready;
  assign in_fire       = in_valid & in_ready;
  assign out_valid_nxt = in_fire | (out_valid_r & ~out_ready);

  c32dfr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  c32dfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .rx_byte (in_rx_byte),
    .cfg     (cfg),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = res_r.status;
  assign out_payload_valid      = res_r.payload_valid;
  assign out_payload_byte       = res_r.payload_byte;
  assign out_payload_index      = res_r.payload_index;
  assign out_msg_type           = res_r.msg_type;
  assign out_msg_flags          = res_r.msg_flags;
  assign out_msg_sequence       = res_r.msg_sequence;
  assign out_msg_payload_length = res_r.msg_payload_length;
  assign out_bad_frames         = res_r.bad_frames;

endmodule
